// ===== rtl/dfie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfie_pkg
// Shared types, constants and the twiddle table of the DFT engine.
// ----------------------------------------------------------------------------
package dfie_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_LOG2   = 6;
    localparam int SAMPLE_W   = 16;
    localparam int TW_FRAC    = 15;
    localparam int TW_W       = 16;
    localparam int OUT_W      = 24;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int LOG2_W     = 3;
    localparam int SHIFT_W    = 5;
    localparam int PROD_W     = SAMPLE_W + TW_W;
    localparam int ACC_W      = 40;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [0:0] {
        CFG_POINT_LOG2   = 1'b0,
        CFG_INVERSE_MODE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic                       last_sample;
    } t_sample;

    typedef struct packed {
        logic signed [OUT_W-1:0] bin_re;
        logic signed [OUT_W-1:0] bin_im;
        logic [IDX_W-1:0]        bin_index;
        logic                    last_bin;
    } t_bin;

    // quarter-wave sine in Q1.15, entries 0..16 of a 64-step circle
    function automatic logic signed [TW_W-1:0] quarter_sine(input logic [4:0] r);
        logic signed [TW_W-1:0] v;
        unique case (r)
            5'd0:    v = 16'sd0;
            5'd1:    v = 16'sd3212;
            5'd2:    v = 16'sd6393;
            5'd3:    v = 16'sd9512;
            5'd4:    v = 16'sd12540;
            5'd5:    v = 16'sd15447;
            5'd6:    v = 16'sd18205;
            5'd7:    v = 16'sd20788;
            5'd8:    v = 16'sd23170;
            5'd9:    v = 16'sd25330;
            5'd10:   v = 16'sd27246;
            5'd11:   v = 16'sd28899;
            5'd12:   v = 16'sd30274;
            5'd13:   v = 16'sd31357;
            5'd14:   v = 16'sd32138;
            5'd15:   v = 16'sd32610;
            5'd16:   v = 16'sd32767;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // full-circle sine from the quarter table
    function automatic logic signed [TW_W-1:0] sine_at(input logic [IDX_W-1:0] a);
        logic [4:0]             r;
        logic [4:0]             rm;
        logic signed [TW_W-1:0] v;
        r  = {1'b0, a[3:0]};
        rm = 5'd16 - r;
        unique case (a[5:4])
            2'd0:    v = quarter_sine(r);
            2'd1:    v = quarter_sine(rm);
            2'd2:    v = -quarter_sine(r);
            default: v = -quarter_sine(rm);
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/dft_forward_inverse_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft_forward_inverse_engine
// Direct fixed-point DFT / inverse DFT over up to 64 loaded complex samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  sample    in         i_in_valid / o_in_stall      i_sample (t_sample)
//  bin       out        o_out_valid / i_out_stall    o_bin (t_bin)
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  a sample beat that is not last is stored, if the store has room, and the engine stays idle
//  a last beat starts a run of N bins; each bin steps through fetch and MAC
//  for each of M loaded samples, then round and done; a 16x16 multiplier
//  forms four products per sample in turn; input stalls for the run
//  a finished bin sits in the output register while the next one is computed
//  synchronous active-low reset; sample store has no reset
// ----------------------------------------------------------------------------
module dft_forward_inverse_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  dfie_pkg::t_sample                   i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output dfie_pkg::t_bin                      o_bin,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  dfie_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [dfie_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dfie_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_MAC   = 5'b00100,
        S_ROUND = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[OUT_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    logic [2*SAMPLE_W-1:0] mem [MAX_POINTS];
    logic [2*SAMPLE_W-1:0] r_rd;

    t_state                   r_state, n_state;
    logic [LOG2_W-1:0]        r_point_log2;
    logic                     r_inverse_mode;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_nload, n_nload;
    logic [LOG2_W-1:0]        r_lg, n_lg;
    logic                     r_inv, n_inv;
    logic [SHIFT_W-1:0]       r_shift, n_shift;
    logic [IDX_W-1:0]         r_mask, n_mask;
    logic [IDX_W-1:0]         r_k, n_k;
    logic [IDX_W-1:0]         r_n, n_n;
    logic [IDX_W-1:0]         r_angle, n_angle;
    logic [2:0]               r_ph, n_ph;
    logic signed [TW_W-1:0]   r_cos, n_cos;
    logic signed [TW_W-1:0]   r_sin, n_sin;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc_re, n_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im, n_acc_im;
    logic                     r_out_valid, n_out_valid;
    t_bin                     r_bin, n_bin;

    logic                     w_in_acc;
    logic                     w_out_acc;
    logic [IDX_W-1:0]         w_a;
    logic signed [TW_W-1:0]   w_sin;
    logic signed [TW_W-1:0]   w_cos;
    logic signed [SAMPLE_W-1:0] w_xr, w_xi;
    logic signed [SAMPLE_W-1:0] w_opa;
    logic signed [TW_W-1:0]   w_opb;
    logic signed [ACC_W-1:0]  w_prod_x;
    logic signed [ACC_W-1:0]  w_rc;
    logic [LOG2_W-1:0]        w_lg;

    assign w_in_acc  = i_in_valid && (r_state == S_IDLE);
    assign w_out_acc = r_out_valid && !i_out_stall;

    // k*n mod N scaled onto the 64-step circle; truncation drops the wrap
    assign w_a   = IDX_W'(r_angle << (LOG2_W'(MAX_LOG2) - r_lg));
    assign w_sin = sine_at(w_a);
    assign w_cos = sine_at(w_a + IDX_W'(MAX_POINTS / 4));

    assign w_xr = r_rd[2*SAMPLE_W-1:SAMPLE_W];
    assign w_xi = r_rd[SAMPLE_W-1:0];

    // phase 0: xr*c, 1: xi*s, 2: xi*c, 3: xr*s
    assign w_opa    = (r_ph == 3'd1 || r_ph == 3'd2) ? w_xi : w_xr;
    assign w_opb    = r_ph[0] ? r_sin : r_cos;
    assign w_prod_x = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_rc     = $signed(ACC_W'(1) << (r_shift - SHIFT_W'(1)));
    assign w_lg     = (r_point_log2 > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : r_point_log2;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_nload     = r_nload;
        n_lg        = r_lg;
        n_inv       = r_inv;
        n_shift     = r_shift;
        n_mask      = r_mask;
        n_k         = r_k;
        n_n         = r_n;
        n_angle     = r_angle;
        n_ph        = r_ph;
        n_cos       = r_cos;
        n_sin       = r_sin;
        n_prod      = r_prod;
        n_acc_re    = r_acc_re;
        n_acc_im    = r_acc_im;
        n_bin       = r_bin;
        n_out_valid = w_out_acc ? 1'b0 : r_out_valid;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_sample.last_sample) begin
                        n_nload  = r_count + CNT_W'(!r_count[CNT_W-1]);
                        n_count  = '0;
                        n_lg     = w_lg;
                        n_inv    = r_inverse_mode;
                        n_shift  = SHIFT_W'(TW_FRAC) +
                                   (r_inverse_mode ? SHIFT_W'(w_lg) : '0);
                        n_mask   = IDX_W'((CNT_W'(1) << w_lg) - CNT_W'(1));
                        n_k      = '0;
                        n_n      = '0;
                        n_angle  = '0;
                        n_acc_re = '0;
                        n_acc_im = '0;
                        n_state  = S_FETCH;
                    end else if (!r_count[CNT_W-1]) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            S_FETCH: begin
                // inverse mode is the forward sum with the sine negated
                n_cos   = w_cos;
                n_sin   = r_inv ? -w_sin : w_sin;
                n_ph    = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                n_prod = w_opa * w_opb;
                unique case (r_ph)
                    3'd1, 3'd2: n_acc_re = r_acc_re + w_prod_x;
                    3'd3:       n_acc_im = r_acc_im + w_prod_x;
                    3'd4:       n_acc_im = r_acc_im - w_prod_x;
                    default:    ;
                endcase
                if (r_ph == 3'd4) begin
                    if ({1'b0, r_n} + CNT_W'(1) == r_nload) begin
                        n_state = S_ROUND;
                    end else begin
                        n_n     = r_n + IDX_W'(1);
                        n_angle = r_angle + r_k;
                        n_state = S_FETCH;
                    end
                end else begin
                    n_ph = r_ph + 3'd1;
                end
            end
            S_ROUND: begin
                n_acc_re = r_acc_re + w_rc;
                n_acc_im = r_acc_im + w_rc;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_bin.bin_re    = sat_out(r_acc_re >>> r_shift);
                    n_bin.bin_im    = sat_out(r_acc_im >>> r_shift);
                    n_bin.bin_index = r_k;
                    n_bin.last_bin  = (r_k == r_mask);
                    n_out_valid     = 1'b1;
                    if (r_k == r_mask) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k      = r_k + IDX_W'(1);
                        n_n      = '0;
                        n_angle  = '0;
                        n_acc_re = '0;
                        n_acc_im = '0;
                        n_state  = S_FETCH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
            r_point_log2   <= LOG2_W'(MAX_LOG2);
            r_inverse_mode <= 1'b0;
            r_nload        <= CNT_W'(1);
            r_mask         <= '0;
            r_ph           <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_nload     <= n_nload;
            r_mask      <= n_mask;
            r_ph        <= n_ph;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_POINT_LOG2:   r_point_log2   <= i_cfg_data;
                    CFG_INVERSE_MODE: r_inverse_mode <= i_cfg_data[0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lg     <= n_lg;
        r_inv    <= n_inv;
        r_shift  <= n_shift;
        r_k      <= n_k;
        r_n      <= n_n;
        r_angle  <= n_angle;
        r_cos    <= n_cos;
        r_sin    <= n_sin;
        r_prod   <= n_prod;
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
        r_bin    <= n_bin;
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !r_count[CNT_W-1]) begin
            mem[r_count[IDX_W-1:0]] <= {i_sample.sample_re, i_sample.sample_im};
        end
        r_rd <= mem[r_n];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_bin       = r_bin;
    assign o_cfg_ready = 1'b1;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_nload_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_nload != '0 && r_nload <= CNT_W'(MAX_POINTS)))
        else $error("run started with bad sample count");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_ph <= 3'd4))
        else $error("mac phase out of range");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bin.last_bin) |-> (o_bin.bin_index == r_mask))
        else $error("last bin flagged on wrong index");

    // the last bin moving into the output register ends the run
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_k == r_mask && (!r_out_valid || !i_out_stall)) |=>
        (r_state == S_IDLE))
        else $error("run did not end after last bin");

endmodule

// ===== bench/dft_forward_inverse_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft_forward_inverse_engine_tb
// Loads sample sets of many lengths under many transform lengths and both
// directions. Each bin beat the engine returns is compared with the next
// expected bin computed in the bench. Both sides of the engine idle at random.
// ----------------------------------------------------------------------------
module dft_forward_inverse_engine_tb;
    import dfie_pkg::*;

    localparam int ITEMS_PER_PHASE = 32;
    localparam int HOLD_CYCLES     = 600;
    localparam int QUIET_LIMIT     = 4000;

    // bin predictor and queue of bins still owed by the engine
    class dft_bin_predictor;
        logic signed [SAMPLE_W-1:0] store_re [MAX_POINTS];
        logic signed [SAMPLE_W-1:0] store_im [MAX_POINTS];
        int                         loaded;
        logic [LOG2_W-1:0]          point_log2;
        logic                       inverse;
        t_bin                       expected_bins [$];
        int                         errors;

        function new();
            loaded     = 0;
            point_log2 = 3'd6;
            inverse    = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_POINT_LOG2) begin
                point_log2 = data;
            end else begin
                inverse = data[0];
            end
        endfunction

        function int quarter_sine(int r);
            case (r)
                0:  return 0;
                1:  return 3212;
                2:  return 6393;
                3:  return 9512;
                4:  return 12540;
                5:  return 15447;
                6:  return 18205;
                7:  return 20788;
                8:  return 23170;
                9:  return 25330;
                10: return 27246;
                11: return 28899;
                12: return 30274;
                13: return 31357;
                14: return 32138;
                15: return 32610;
                16: return 32767;
                default: return 0;
            endcase
        endfunction

        // angle in steps of 2*pi/64
        function int sine_of(int a);
            int q;
            int r;
            a = a & (MAX_POINTS - 1);
            q = a / (MAX_POINTS / 4);
            r = a % (MAX_POINTS / 4);
            case (q)
                0:       return quarter_sine(r);
                1:       return quarter_sine(MAX_POINTS / 4 - r);
                2:       return -quarter_sine(r);
                default: return -quarter_sine(MAX_POINTS / 4 - r);
            endcase
        endfunction

        // round to nearest, ties up, then clip to the output width
        function logic signed [OUT_W-1:0] round_sat(longint v, int sh);
            longint r;
            longint hi;
            hi = (longint'(1) <<< (OUT_W - 1)) - 1;
            r  = (v + (longint'(1) <<< (sh - 1))) >>> sh;
            if (r > hi) begin
                r = hi;
            end else if (r < -hi - 1) begin
                r = -hi - 1;
            end
            return r[OUT_W-1:0];
        endfunction

        function void compute_bins();
            int     lg;
            int     npts;
            int     stride;
            int     shift;
            int     a;
            longint acc_re;
            longint acc_im;
            longint c;
            longint s;
            longint xr;
            longint xi;
            t_bin   b;
            lg     = (point_log2 > MAX_LOG2) ? MAX_LOG2 : int'(point_log2);
            npts   = 1 << lg;
            stride = MAX_POINTS / npts;
            shift  = TW_FRAC + (inverse ? lg : 0);
            for (int k = 0; k < npts; k++) begin
                acc_re = 0;
                acc_im = 0;
                for (int n = 0; n < loaded; n++) begin
                    a  = ((k * n) & (npts - 1)) * stride;
                    c  = longint'(sine_of(a + MAX_POINTS / 4));
                    s  = longint'(sine_of(a));
                    xr = longint'(store_re[n]);
                    xi = longint'(store_im[n]);
                    if (inverse) begin
                        acc_re += xr * c - xi * s;
                        acc_im += xi * c + xr * s;
                    end else begin
                        acc_re += xr * c + xi * s;
                        acc_im += xi * c - xr * s;
                    end
                end
                b.bin_re    = round_sat(acc_re, shift);
                b.bin_im    = round_sat(acc_im, shift);
                b.bin_index = IDX_W'(k);
                b.last_bin  = (k == npts - 1);
                expected_bins.push_back(b);
            end
        endfunction

        function void take_sample(t_sample beat);
            // samples past the store depth are dropped
            if (loaded < MAX_POINTS) begin
                store_re[loaded] = beat.sample_re;
                store_im[loaded] = beat.sample_im;
                loaded++;
            end
            if (beat.last_sample) begin
                compute_bins();
                loaded = 0;
            end
        endfunction

        function void check_bin(t_bin got);
            t_bin want;
            if (expected_bins.size() == 0) begin
                $error("bin beat with nothing expected, bin_index %0d", got.bin_index);
                errors++;
                return;
            end
            want = expected_bins.pop_front();
            if (got.bin_re !== want.bin_re) begin
                $error("bin_re: expected %0d, got %0d", want.bin_re, got.bin_re);
                errors++;
            end
            if (got.bin_im !== want.bin_im) begin
                $error("bin_im: expected %0d, got %0d", want.bin_im, got.bin_im);
                errors++;
            end
            if (got.bin_index !== want.bin_index) begin
                $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
                errors++;
            end
            if (got.last_bin !== want.last_bin) begin
                $error("last_bin: expected %0d, got %0d", want.last_bin, got.last_bin);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bins.size();
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    t_sample                 i_sample    = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_bin                    o_bin;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    t_cfg_idx                i_cfg_index = CFG_POINT_LOG2;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    dft_bin_predictor bin_calc = new();

    int tx_idle_pct   = 20;
    int rx_idle_pct   = 88;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    dft_forward_inverse_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_bin       (o_bin),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            bin_calc.check_bin(o_bin);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_sample sample_of(input int re, input int im, input bit last);
        t_sample s;
        s.sample_re   = SAMPLE_W'(re);
        s.sample_im   = SAMPLE_W'(im);
        s.last_sample = last;
        return s;
    endfunction

    function automatic int rand_word();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return int'($urandom_range(0, 32)) - 16;
            3:       return 0;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(input t_sample beat);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bin_calc.take_sample(beat);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bin_calc.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [2:0] lg, input logic [2:0] inv_word);
        write_reg(CFG_POINT_LOG2, lg);
        write_reg(CFG_INVERSE_MODE, inv_word);
        i_cfg_valid <= 1'b0;
    endtask

    // sender pauses until every owed bin is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (bin_calc.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int lg;
        int npts;
        int set_len;
        int phase_items;
        int pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sets, first one under the reset settings
        send_sample(sample_of(32767, -32768, 1'b1));
        drain();

        set_config(3'd0, 3'b000);
        send_sample(sample_of(-32768, 32767, 1'b1));
        drain();

        // fewer samples than points, inverse
        set_config(3'd3, 3'b001);
        send_sample(sample_of(32767, 32767, 1'b0));
        send_sample(sample_of(-32768, -32768, 1'b0));
        send_sample(sample_of(-1, 1, 1'b1));
        drain();

        // more samples than points wrap the angle
        set_config(3'd1, 3'b110);
        send_sample(sample_of(1000, -2000, 1'b0));
        send_sample(sample_of(-32768, 0, 1'b0));
        send_sample(sample_of(0, 32767, 1'b0));
        send_sample(sample_of(12345, -12345, 1'b0));
        send_sample(sample_of(-1, -1, 1'b1));
        drain();

        // length code above six acts as six
        set_config(3'd7, 3'b111);
        send_sample(sample_of(16'h5555, 16'haaaa, 1'b0));
        send_sample(sample_of(16'haaaa, 16'h5555, 1'b0));
        send_sample(sample_of(32767, -32768, 1'b0));
        send_sample(sample_of(-32768, 32767, 1'b1));
        drain();

        set_config(3'd2, 3'b000);
        send_sample(sample_of(1, 0, 1'b0));
        send_sample(sample_of(0, 1, 1'b0));
        send_sample(sample_of(-1, 0, 1'b0));
        send_sample(sample_of(0, -1, 1'b1));
        drain();

        for (int p = 0; p < 9; p++) begin
            case (p / 3)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 88;
                end
                1: begin
                    tx_idle_pct = 88;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (p)
                1:       lg = 6;
                4:       lg = 0;
                6:       lg = 3;
                7:       lg = 7;
                default: lg = $urandom_range(0, 7);
            endcase
            set_config(3'(lg), {2'($urandom_range(0, 3)), p[0]});
            npts = 1 << ((lg > MAX_LOG2) ? MAX_LOG2 : lg);
            // receiver holds off while the sender keeps offering beats
            if (p == 6) begin
                hold_requests++;
            end
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (p == 0 && phase_items == 0) begin
                    set_len = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 6);
                end else if (pick < 3) begin
                    set_len = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
                end else if (pick < 8) begin
                    set_len = MAX_POINTS;
                end else if (pick < 35) begin
                    set_len = $urandom_range(1, npts + 2);
                end else begin
                    set_len = $urandom_range(1, 6);
                end
                for (int i = 0; i < set_len; i++) begin
                    send_sample(sample_of(rand_word(),
                                          ($urandom_range(0, 4) == 0) ? 0 : rand_word(),
                                          i == set_len - 1));
                end
                phase_items += set_len;
            end
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (bin_calc.errors == 0 && bin_calc.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dfie_pkg.sv
rtl/dft_forward_inverse_engine.sv
bench/dft_forward_inverse_engine_tb.sv
